### rtl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int MEAS_W = 16;
  localparam int GAIN_W = 16;
  localparam int CTRL_W = 32;
  localparam int ERR_W  = MEAS_W + 1;
  localparam int ACC_W  = 50;
  localparam int RAW_W  = ACC_W - GAIN_FRAC_BITS;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CTRL_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [CTRL_W-1:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_TARGET     = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_GAIN_D     = 3'd4,
    REG_LIMIT_HIGH = 3'd5,
    REG_LIMIT_LOW  = 3'd6
  } reg_idx_t;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [MEAS_W-1:0]  target;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [CTRL_W-1:0]  limit_high;
    logic [CTRL_W-1:0]  limit_low;
  } cfg_t;

  typedef struct packed {
    logic [CTRL_W-1:0] value;
    logic              sat;
  } res_t;

endpackage

`default_nettype wire

### rtl/pidc_dp.sv
`default_nettype none

module pidc_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [pidc_pkg::MEAS_W-1:0] meas,
  input  wire pidc_pkg::cfg_t             cfg,
  output pidc_pkg::res_t                  res
);

  localparam int ERR_W  = pidc_pkg::ERR_W;
  localparam int CTRL_W = pidc_pkg::CTRL_W;
  localparam int ACC_W  = pidc_pkg::ACC_W;
  localparam int RAW_W  = pidc_pkg::RAW_W;
  localparam int GW     = pidc_pkg::GAIN_W;
  localparam int SUM_W  = CTRL_W + 1;
  localparam int D1_W   = ERR_W + 1;
  localparam int D2_W   = ERR_W + 2;
  localparam int PP_W   = D1_W + GW;
  localparam int PI_W   = CTRL_W + GW;
  localparam int PD_W   = D2_W + GW;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  err1_r;
  logic signed [ERR_W-1:0]  err2_r;
  logic signed [CTRL_W-1:0] sum_r;
  logic signed [SUM_W-1:0]  sum_wide;
  logic signed [CTRL_W-1:0] cand;
  logic                     isat;
  logic signed [D1_W-1:0]   d1;
  logic signed [D2_W-1:0]   d2;
  logic                     inc;
  logic signed [GW-1:0]     kp;
  logic signed [GW-1:0]     ki;
  logic signed [GW-1:0]     kd;
  logic signed [D1_W-1:0]   op_p;
  logic signed [CTRL_W-1:0] op_i;
  logic signed [D2_W-1:0]   op_d;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RAW_W-1:0]  raw;
  logic signed [RAW_W-1:0]  lim_hi;
  logic signed [RAW_W-1:0]  lim_lo;
  logic signed [RAW_W-1:0]  raw_max;
  logic signed [RAW_W-1:0]  raw_min;
  logic                     above;
  logic                     below;
  logic                     commit;
  logic                     ovf_hi;
  logic                     ovf_lo;

  assign err = ERR_W'($signed(cfg.target)) - ERR_W'($signed(meas));
  assign d1  = D1_W'(err) - D1_W'(err1_r);
  assign d2  = D2_W'(err) - (D2_W'(err1_r) <<< 1) + D2_W'(err2_r);

  // integral candidate, saturated to 32 bits
  assign sum_wide = SUM_W'(sum_r) + SUM_W'(err);
  assign isat     = sum_wide[SUM_W-1] != sum_wide[SUM_W-2];
  assign cand     = isat ? (sum_wide[SUM_W-1] ? $signed(pidc_pkg::S32_MIN)
                                              : $signed(pidc_pkg::S32_MAX))
                         : sum_wide[CTRL_W-1:0];

  assign inc = cfg.mode == pidc_pkg::MODE_INCREMENTAL;
  assign kp  = $signed(cfg.gain_p);
  assign ki  = $signed(cfg.gain_i);
  assign kd  = $signed(cfg.gain_d);

  // the three multipliers are shared between the two modes
  assign op_p = inc ? d1 : D1_W'(err);
  assign op_i = inc ? CTRL_W'(err) : cand;
  assign op_d = inc ? d2 : D2_W'(d1);

  assign prod_p = kp * op_p;
  assign prod_i = ki * op_i;
  assign prod_d = kd * op_d;

  assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
  // floor shift drops the fraction bits
  assign raw = acc[ACC_W-1:pidc_pkg::GAIN_FRAC_BITS];

  assign lim_hi  = RAW_W'($signed(cfg.limit_high));
  assign lim_lo  = RAW_W'($signed(cfg.limit_low));
  assign raw_max = RAW_W'($signed(pidc_pkg::S32_MAX));
  assign raw_min = RAW_W'($signed(pidc_pkg::S32_MIN));

  assign above  = raw > lim_hi;
  assign below  = raw < lim_lo;
  assign commit = !inc && (raw < lim_hi) && (raw > lim_lo);
  assign ovf_hi = raw > raw_max;
  assign ovf_lo = raw < raw_min;

  always_comb begin
    res = '0;
    if (inc) begin
      priority if (ovf_hi) begin
        res.value = pidc_pkg::S32_MAX;
        res.sat   = 1'b1;
      end else if (ovf_lo) begin
        res.value = pidc_pkg::S32_MIN;
        res.sat   = 1'b1;
      end else begin
        res.value = raw[CTRL_W-1:0];
        res.sat   = 1'b0;
      end
    end else begin
      priority if (above) begin
        res.value = cfg.limit_high;
        res.sat   = 1'b1;
      end else if (below) begin
        res.value = cfg.limit_low;
        res.sat   = 1'b1;
      end else begin
        res.value = raw[CTRL_W-1:0];
        res.sat   = isat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err1_r <= '0;
      err2_r <= '0;
      sum_r  <= '0;
    end else if (step) begin
      err2_r <= err1_r;
      err1_r <= err;
      if (commit) begin
        sum_r <= cand;
      end
    end
  end

`ifndef SYNTHESIS
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && commit) |=> sum_r == $past(sum_r))
    else $error("integral changed without a commit");

  a_inc_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    step && inc |=> sum_r == $past(sum_r))
    else $error("integral committed in incremental mode");

  a_commit_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
    step && commit |-> res.value == raw[CTRL_W-1:0] && res.sat == isat)
    else $error("committed integral with a clamped output");

  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> err2_r == $past(err1_r))
    else $error("error history did not shift");
`endif

endmodule

`default_nettype wire

### rtl/pid_controller_dual_mode.sv
`default_nettype none

// Dual-mode PID controller. Each input word carries one measured sample; each
// produces exactly one output word. An item is taken every cycle when the output
// side keeps up, passing through an input register, then a result register.
// The rate is set by the per-item loop through the integral: the error, the
// saturated integral candidate, the three Q8.8 gain multipliers (the widest
// 16x32), the product sum and the limit compares that decide the integral
// commit all resolve combinationally between the two registers.
// Registers (APB, byte address 4*index): mode, target, gain_p, gain_i, gain_d,
// limit_high, limit_low. Write configuration only while the block is idle.
module pid_controller_dual_mode (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [pidc_pkg::MEAS_W-1:0]        in_measured_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [pidc_pkg::CTRL_W-1:0]             out_control_value,
  output logic                                    out_saturated,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pidc_pkg::APB_AW-1:0]        paddr,
  input  wire logic [pidc_pkg::APB_DW-1:0]        pwdata,
  output logic [pidc_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);

  localparam int MW = pidc_pkg::MEAS_W;
  localparam int GW = pidc_pkg::GAIN_W;
  localparam int CW = pidc_pkg::CTRL_W;
  localparam int DW = pidc_pkg::APB_DW;

  pidc_pkg::cfg_t   cfg_r;
  pidc_pkg::reg_idx_t reg_idx;
  pidc_pkg::res_t   res;
  logic             wr_en;

  logic             s1_valid_r;
  logic [MW-1:0]    meas_r;
  logic             s1_adv;
  logic             step;
  logic             out_valid_r;
  logic [CW-1:0]    out_value_r;
  logic             out_sat_r;

  // configuration port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = pidc_pkg::reg_idx_t'(paddr[pidc_pkg::APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= pidc_pkg::MODE_POSITIONAL;
      cfg_r.target     <= '0;
      cfg_r.gain_p     <= '0;
      cfg_r.gain_i     <= '0;
      cfg_r.gain_d     <= '0;
      cfg_r.limit_high <= pidc_pkg::S32_MAX;
      cfg_r.limit_low  <= pidc_pkg::S32_MIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        pidc_pkg::REG_MODE:       cfg_r.mode       <= pidc_pkg::mode_t'(pwdata[0]);
        pidc_pkg::REG_TARGET:     cfg_r.target     <= pwdata[MW-1:0];
        pidc_pkg::REG_GAIN_P:     cfg_r.gain_p     <= pwdata[GW-1:0];
        pidc_pkg::REG_GAIN_I:     cfg_r.gain_i     <= pwdata[GW-1:0];
        pidc_pkg::REG_GAIN_D:     cfg_r.gain_d     <= pwdata[GW-1:0];
        pidc_pkg::REG_LIMIT_HIGH: cfg_r.limit_high <= pwdata[CW-1:0];
        pidc_pkg::REG_LIMIT_LOW:  cfg_r.limit_low  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pidc_pkg::REG_MODE:       prdata = DW'(cfg_r.mode);
      pidc_pkg::REG_TARGET:     prdata = DW'($signed(cfg_r.target));
      pidc_pkg::REG_GAIN_P:     prdata = DW'($signed(cfg_r.gain_p));
      pidc_pkg::REG_GAIN_I:     prdata = DW'($signed(cfg_r.gain_i));
      pidc_pkg::REG_GAIN_D:     prdata = DW'($signed(cfg_r.gain_d));
      pidc_pkg::REG_LIMIT_HIGH: prdata = cfg_r.limit_high;
      pidc_pkg::REG_LIMIT_LOW:  prdata = cfg_r.limit_low;
      default:                  prdata = '0;
    endcase
  end

  // input register moves into the result register when that one is empty or being read out
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign step     = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r <= in_measured_value;
    end
    if (step) begin
      out_value_r <= res.value;
      out_sat_r   <= res.sat;
    end
  end

  pidc_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .meas  (meas_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid         = out_valid_r;
  assign out_control_value = out_value_r;
  assign out_saturated     = out_sat_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && meas_r == $past(meas_r))
    else $error("held word lost from the input register");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("computed word did not reach the result register");
`endif

endmodule

`default_nettype wire
